// ----- design/fpw_pkg.sv -----
// Shared widths, codes and types of the four-level page walker.
package fpw_pkg;

  // Default store depth in 64-bit words
  localparam int TABLE_WORDS_DEF = 4096;

  // Field widths
  localparam int OP_W    = 1;
  localparam int WIDX_W  = 12;
  localparam int DATA_W  = 64;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ST_W    = 2;

  // Page-table geometry
  localparam int IDX_W   = 9;
  localparam int OFF4K_W = 12;
  localparam int OFF2M_W = 21;
  localparam int PFN_W   = PA_W - OFF4K_W;
  localparam int WORD_W  = PFN_W + IDX_W;

  // Entry bit positions
  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  // APB port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam int REG_SEL_BIT = 3;

  // Item operations
  localparam logic [OP_W-1:0] OP_WRITE     = 1'b0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 1'b1;

  // Register indexes
  localparam logic REG_TABLE_ROOT = 1'b0;

  // Result status
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // One result item
  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    status_t         status;
    logic            large_page;
  } res_t;

endpackage

// ----- design/fpw_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface fpw_in_if import fpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [WIDX_W-1:0] word_index;
  logic [DATA_W-1:0] write_data;
  logic [VA_W-1:0]   virt_addr;

  modport source (output valid, operation, word_index, write_data, virt_addr,
                  input ready);
  modport sink (input valid, operation, word_index, write_data, virt_addr,
                output ready);
endinterface

interface fpw_out_if import fpw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_addr;
  logic [ST_W-1:0] status;
  logic            large_page;

  modport source (output valid, phys_addr, status, large_page, input ready);
  modport sink (input valid, phys_addr, status, large_page, output ready);
endinterface

// ----- design/four_level_page_walk.sv -----
// Top level of the four-level page walker.
//
// Input channel in_if carries one item per transaction: a table write
// (operation 0: word_index, write_data) or a translation (operation 1:
// virt_addr). Every item gives exactly one result transaction on out_if:
// phys_addr, status (ok, not present, outside store) and large_page.
// The APB port holds table_root at byte address 0; software must write it
// only while no item is in flight, and the block itself does not enforce this. pready is tied high.
// Items are handled one at a time. A write moves to the done state on
// acceptance, and its result then loads the output register. A translation
// spends a fetch state (a registered table read) and then a check state (the
// entry check) on each level visited, then loads the output register from the
// done state. The next item is accepted the cycle after the result
// moves into the output register.
// A result waiting in the output register does not block the next item;
// if it is still unread when the following result is ready, the walker
// holds that result and accepts nothing further until out_if drains.
// Synchronous reset clears the root, the sequencer and the output valid;
// the table store keeps no reset and must be written before it is read.
module four_level_page_walk import fpw_pkg::*; #(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fpw_in_if.sink                in_if,
  fpw_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [PA_W-1:0]   table_root;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Register block
  fpw_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .table_root (table_root)
  );

  // Table store
  fpw_table_mem #(.TABLE_WORDS(TABLE_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Walk sequencer and result register
  fpw_walker #(.TABLE_WORDS(TABLE_WORDS)) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .table_root (table_root),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule

// ----- design/fpw_cfg.sv -----
// APB register block holding the top-level table root.
module fpw_cfg import fpw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [PA_W-1:0]       table_root
);

  logic [PA_W-1:0] root_r;
  logic [PA_W-1:0] root_nxt;
  logic            root_sel;

  assign root_sel = (paddr[REG_SEL_BIT] == REG_TABLE_ROOT);

  // Take the root on the access phase of a write
  always_comb begin
    root_nxt = root_r;
    if (psel && penable && pwrite && root_sel) begin
      root_nxt = pwdata[PA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else begin
      root_r <= root_nxt;
    end
  end

  // Read back; unmapped addresses return zero
  assign prdata     = root_sel ? APB_DATA_W'(root_r) : '0;
  assign pready     = 1'b1;
  assign table_root = root_r;

endmodule

// ----- design/fpw_table_mem.sv -----
// Page-table store: one write port, one read port with registered data.
module fpw_table_mem import fpw_pkg::*; #(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [TABLE_WORDS];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/fpw_walker.sv -----
// Walk sequencer: table writes, four-level lookups and the result register.
module fpw_walker import fpw_pkg::*; #(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic              clk,
  input  logic              rst_n,
  fpw_in_if.sink            in_if,
  fpw_out_if.source         out_if,
  input  logic [PA_W-1:0]   table_root,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [DATA_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_CHECK = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Level codes: top table down to leaf table
  localparam logic [1:0] LVL_4 = 2'd3;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_1 = 2'd0;

  localparam logic [WORD_W-1:0] WORD_LIMIT = WORD_W'(TABLE_WORDS);

  state_t             state_r, state_nxt;
  logic [1:0]         lvl_r, lvl_nxt;
  logic [PFN_W-1:0]   base_r, base_nxt;
  logic [VA_W-1:0]    va_r, va_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  logic               in_accept;
  logic               push;
  logic [IDX_W-1:0]   idx;
  logic [WORD_W-1:0]  word;
  logic               word_in_store;
  logic [DATA_W-1:0]  entry;

  assign in_accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  // Store writes go straight to memory on acceptance
  assign mem_we    = in_accept && (in_if.operation == OP_WRITE) &&
                     (32'(in_if.word_index) < 32'(TABLE_WORDS));
  assign mem_waddr = AW'(in_if.word_index);
  assign mem_wdata = in_if.write_data;

  // Select the index field of the current level
  always_comb begin
    unique case (lvl_r)
      LVL_4:   idx = va_r[OFF4K_W + 3*IDX_W +: IDX_W];
      LVL_3:   idx = va_r[OFF4K_W + 2*IDX_W +: IDX_W];
      LVL_2:   idx = va_r[OFF4K_W + IDX_W +: IDX_W];
      default: idx = va_r[OFF4K_W +: IDX_W];
    endcase
  end

  // Base is 4 KB aligned, so the word address is a concatenation
  assign word          = {base_r, idx};
  assign word_in_store = (word < WORD_LIMIT);
  assign mem_re        = (state_r == S_FETCH) && word_in_store;
  assign mem_raddr     = word[AW-1:0];
  assign entry         = mem_rdata;

  assign push = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    base_nxt  = base_r;
    va_nxt    = va_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_nxt = '0;
          if (in_if.operation == OP_WRITE) begin
            state_nxt = S_DONE;
          end else begin
            base_nxt  = table_root[PA_W-1:OFF4K_W];
            va_nxt    = in_if.virt_addr;
            lvl_nxt   = LVL_4;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (word_in_store) begin
          state_nxt = S_CHECK;
        end else begin
          res_nxt.status = ST_OUTSIDE;
          state_nxt      = S_DONE;
        end
      end
      S_CHECK: begin
        priority if (!entry[PRESENT_BIT]) begin
          res_nxt.status = ST_ABSENT;
          state_nxt      = S_DONE;
        end else if ((lvl_r == LVL_2) && entry[LARGE_BIT]) begin
          res_nxt.phys_addr  = {entry[PA_W-1:OFF2M_W], va_r[OFF2M_W-1:0]};
          res_nxt.large_page = 1'b1;
          state_nxt          = S_DONE;
        end else if (lvl_r == LVL_1) begin
          res_nxt.phys_addr = {entry[PA_W-1:OFF4K_W], va_r[OFF4K_W-1:0]};
          state_nxt         = S_DONE;
        end else begin
          base_nxt  = entry[PA_W-1:OFF4K_W];
          lvl_nxt   = lvl_r - 2'd1;
          state_nxt = S_FETCH;
        end
      end
      S_DONE: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: drain on ready, load on push
  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_res_nxt   = out_res_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    base_r    <= base_nxt;
    va_r      <= va_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.phys_addr  = out_res_r.phys_addr;
  assign out_if.status     = out_res_r.status;
  assign out_if.large_page = out_res_r.large_page;

endmodule

// ----- tb/sv/page_walk_checker.sv -----
// Checker for the page walker: mirrors the table store and root, predicts and compares results.
`timescale 1ns / 1ps

module page_walk_checker import fpw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fpw_in_if                     item_ch,
  fpw_out_if                    res_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int TABLE_WORDS = TABLE_WORDS_DEF;
  localparam logic [APB_ADDR_W-1:0] ROOT_ADDR =
    APB_ADDR_W'(REG_TABLE_ROOT) << REG_SEL_BIT;

  logic [DATA_W-1:0] store_model [TABLE_WORDS];
  logic [PA_W-1:0]   root_model;
  res_t              expected_q [$];

  // Walk the four levels over the mirrored store
  function automatic res_t walk_result(input logic [VA_W-1:0] va);
    res_t              r;
    logic [PA_W-1:0]   base;
    logic [DATA_W-1:0] entry;
    logic [63:0]       word;
    r.phys_addr  = '0;
    r.status     = ST_OK;
    r.large_page = 1'b0;
    base = {root_model[PA_W-1:OFF4K_W], {OFF4K_W{1'b0}}};
    for (int lvl = 4; lvl >= 1; lvl--) begin
      word = 64'(base >> 3) + 64'(va[OFF4K_W + IDX_W*(lvl-1) +: IDX_W]);
      if (word >= TABLE_WORDS) begin
        r.status = ST_OUTSIDE;
        return r;
      end
      entry = store_model[word[WIDX_W-1:0]];
      if (!entry[PRESENT_BIT]) begin
        r.status = ST_ABSENT;
        return r;
      end
      // 2 MB pages end the walk at level 2 only; upper large bits are ignored
      if (lvl == 2 && entry[LARGE_BIT]) begin
        r.phys_addr  = {entry[PA_W-1:OFF2M_W], va[OFF2M_W-1:0]};
        r.large_page = 1'b1;
        return r;
      end
      if (lvl == 1) begin
        r.phys_addr = {entry[PA_W-1:OFF4K_W], va[OFF4K_W-1:0]};
        return r;
      end
      base = {entry[PA_W-1:OFF4K_W], {OFF4K_W{1'b0}}};
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      root_model = '0;
      expected_q.delete();
    end else begin
      // Track root writes on the register port
      if (psel && penable && pwrite && pready && paddr == ROOT_ADDR)
        root_model = pwdata[PA_W-1:0];

      // Predict each accepted input transaction
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.operation == OP_WRITE) begin
          want.phys_addr  = '0;
          want.status     = ST_OK;
          want.large_page = 1'b0;
          if (item_ch.word_index < TABLE_WORDS)
            store_model[item_ch.word_index] = item_ch.write_data;
        end else begin
          want = walk_result(item_ch.virt_addr);
        end
        expected_q.push_back(want);
      end

      // Compare each accepted result transaction with the oldest prediction
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, phys_addr %h status %0d large_page %b",
                   $time, res_ch.phys_addr, res_ch.status, res_ch.large_page);
          fail_count = fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (res_ch.phys_addr !== want.phys_addr) begin
            $display("%0t: phys_addr mismatch, expected %h, actual %h",
                     $time, want.phys_addr, res_ch.phys_addr);
            fail_count = fail_count + 1;
          end
          if (res_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, res_ch.status);
            fail_count = fail_count + 1;
          end
          if (res_ch.large_page !== want.large_page) begin
            $display("%0t: large_page mismatch, expected %b, actual %b",
                     $time, want.large_page, res_ch.large_page);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/sv/tb_four_level_page_walk.sv -----
// Testbench top of the page walker: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_four_level_page_walk import fpw_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [APB_ADDR_W-1:0] ROOT_ADDR =
    APB_ADDR_W'(REG_TABLE_ROOT) << REG_SEL_BIT;

  logic clk = 1'b0;
  logic rst_n;

  fpw_in_if  item_ch ();
  fpw_out_if res_ch ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic res_ready = 1'b0;
  int   rx_hold = 0;
  bit   steady = 1'b0;
  int   stall_cycles = 0;
  int   fail_count;
  int   pending;
  int   items_sent = 0;

  // Stimulus-side copy of the store, used only to keep walks on written words
  logic [DATA_W-1:0] plan_store [TABLE_WORDS_DEF];
  bit                plan_written [TABLE_WORDS_DEF];
  logic [PA_W-1:0]   plan_root = '0;
  logic [VA_W-1:0]   last_va = '0;

  assign res_ch.ready = res_ready;

  four_level_page_walk DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (item_ch),
    .out_if  (res_ch),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  page_walk_checker walk_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_ch    (item_ch),
    .res_ch     (res_ch),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .pready     (cfg_pready),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 2);
    if (r < 18) return $urandom_range(3, 10);
    return $urandom_range(11, 40);
  endfunction

  // Random table entry, biased towards present entries inside the store
  function automatic logic [DATA_W-1:0] random_entry(input int level);
    logic [DATA_W-1:0] e;
    int r;
    e = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (level != 1 && r < 86)
      e[PA_W-1:OFF4K_W] = PFN_W'($urandom_range(0, 7));
    else if (level != 1 && r < 92)
      e[PA_W-1:OFF4K_W] = PFN_W'($urandom_range(8, 15));
    e[PRESENT_BIT] = ($urandom_range(0, 9) != 0);
    if (level == 2)
      e[LARGE_BIT] = ($urandom_range(0, 2) == 0);
    return e;
  endfunction

  // First store word on the walk of va that was never written, or -1
  function automatic int unwritten_on_walk(input logic [VA_W-1:0] va, output int level);
    logic [PA_W-1:0]   base;
    logic [DATA_W-1:0] e;
    logic [63:0]       word;
    level = 0;
    base = {plan_root[PA_W-1:OFF4K_W], {OFF4K_W{1'b0}}};
    for (int lvl = 4; lvl >= 1; lvl--) begin
      word = 64'(base >> 3) + 64'(va[OFF4K_W + IDX_W*(lvl-1) +: IDX_W]);
      if (word >= TABLE_WORDS_DEF) return -1;
      if (!plan_written[word[WIDX_W-1:0]]) begin
        level = lvl;
        return int'(word);
      end
      e = plan_store[word[WIDX_W-1:0]];
      if (!e[PRESENT_BIT] || lvl == 1 || (lvl == 2 && e[LARGE_BIT])) return -1;
      base = {e[PA_W-1:OFF4K_W], {OFF4K_W{1'b0}}};
    end
    return -1;
  endfunction

  // Drive one input transaction and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [WIDX_W-1:0] widx,
                           input logic [DATA_W-1:0] data, input logic [VA_W-1:0] va);
    int gap;
    gap = steady ? 0 : idle_len();
    if (op == OP_WRITE) begin
      plan_store[widx]   = data;
      plan_written[widx] = 1'b1;
    end
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.operation  <= op;
    item_ch.word_index <= widx;
    item_ch.write_data <= data;
    item_ch.virt_addr  <= va;
    item_ch.valid      <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    items_sent = items_sent + 1;
  endtask

  task automatic send_write(input logic [WIDX_W-1:0] widx, input logic [DATA_W-1:0] data);
    send_item(OP_WRITE, widx, data, VA_W'({$urandom, $urandom}));
  endtask

  // Fill any unwritten word on the walk, then translate
  task automatic translate_va(input logic [VA_W-1:0] va);
    int word;
    int level;
    word = unwritten_on_walk(va, level);
    while (word >= 0) begin
      send_write(WIDX_W'(word), random_entry(level));
      word = unwritten_on_walk(va, level);
    end
    last_va = va;
    send_item(OP_TRANSLATE, WIDX_W'($urandom), {$urandom, $urandom}, va);
  endtask

  // Hold input until every result is back
  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write the root over the register port while the walker is idle
  task automatic write_root(input logic [PA_W-1:0] root);
    wait_idle();
    plan_root = root;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ROOT_ADDR;
    cfg_pwdata  <= {12'($urandom), root};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic random_item();
    logic [VA_W-1:0] va;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 1)
        send_write(WIDX_W'($urandom), random_entry($urandom_range(1, 4)));
      else
        send_write(WIDX_W'($urandom), {$urandom, $urandom});
    end else begin
      va = VA_W'({$urandom, $urandom});
      // Revisit the last level-2 table now and then
      if ($urandom_range(0, 3) == 0)
        va[VA_W-1:OFF2M_W] = last_va[VA_W-1:OFF2M_W];
      translate_va(va);
    end
  endtask

  task automatic random_phase(input logic [PA_W-1:0] root, input int count, input bit calm);
    int phase_end;
    write_root(root);
    steady = calm;
    phase_end = items_sent + count;
    while (items_sent < phase_end) random_item();
    steady = 1'b0;
  endtask

  // Result-side stalls
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      res_ready <= 1'b0;
      rx_hold   <= idle_len();
    end else begin
      res_ready <= 1'b1;
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    item_ch.valid      <= 1'b0;
    item_ch.operation  <= OP_WRITE;
    item_ch.word_index <= '0;
    item_ch.write_data <= '0;
    item_ch.virt_addr  <= '0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: root 0 with the ignored low bits set, tables at pages 1..3
    write_root(52'h0_0000_0000_0FFF);
    send_write(12'd0,    64'h0000_0000_0000_1081);
    send_write(12'd512,  64'h0000_0000_0000_2001);
    send_write(12'd1024, 64'h0000_0000_0000_3001);
    send_write(12'd1536, 64'hFFFF_FFFF_FFFF_FFFF);
    send_write(12'd1025, 64'hFFFF_FFFF_FFFF_FFFF);
    send_write(12'd1,    64'hFFFF_FFFF_FFFF_FFFE);
    send_write(12'd513,  64'h0000_0000_0000_0000);
    send_write(12'd1537, 64'hFFFF_FFFF_FFFF_FFFE);
    send_write(12'd2,    64'h0000_0000_0000_8001);
    send_write(12'd3,    64'h000F_FFFF_FFFF_F001);
    send_write(12'd514,  64'h0000_0000_0000_2081);
    send_write(12'd4095, 64'h0000_0000_0000_0000);
    // full 4 KB walk, large bit at the top level ignored
    translate_va(48'h0000_0000_0FFF);
    // 2 MB page
    translate_va(48'h0000_003F_FFFF);
    // not present at the top, middle and last level
    translate_va(48'h0080_0000_0000);
    translate_va(48'h0000_4000_0000);
    translate_va(48'h0000_0000_1000);
    // next table just past the store, and far outside it
    translate_va(48'h0100_0000_0000);
    translate_va(48'h0180_0000_0000);
    // large bit at level 3 does not make a 1 GB page
    translate_va(48'h0000_8000_0ABC);
    translate_va(48'hFFFF_FFFF_FFFF);

    // Random phases over several roots, the extremes among them
    random_phase({40'd7, 12'($urandom)}, 110, 1'b0);
    random_phase(52'hF_FFFF_FFFF_FFFF, 40, 1'b0);
    random_phase({PFN_W'($urandom_range(0, 7)), 12'($urandom)}, 110, 1'b1);
    random_phase(52'h0, 110, 1'b0);
    random_phase({PFN_W'($urandom_range(0, 7)), 12'($urandom)}, 110, 1'b0);
    random_phase({40'd3, 12'h000}, 110, 1'b0);

    // Drain and let the walker settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
